[rtl/accumulator_machine_step_top_macros.svh]
// Assertion helpers, compiled out for synthesis
`ifndef ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define AMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ams: implication check failed");
`define AMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ams: next-cycle check failed");
`else
`define AMS_ASSERT_IMP(lbl, ante, cons)
`define AMS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/ams_pkg.sv]
package ams_pkg;

	localparam int STORE_DEPTH_DEF = 1024;

	localparam int WW   = 18;  // machine word
	localparam int PCW  = 10;  // visible program counter
	localparam int WAW  = 10;  // word_address field
	localparam int OPW  = 13;  // instruction address field
	localparam int OCW  = 5;   // opcode field
	localparam int RW   = 23;  // reciprocal width, enough for depth >= 16
	localparam int RSH  = 26;  // reciprocal scale

	typedef enum logic [1:0] {
		MODE_EXEC  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [OCW-1:0] {
		OP_LOAD  = 5'd1,
		OP_STORE = 5'd2,
		OP_ADD   = 5'd3,
		OP_SUB   = 5'd4,
		OP_SKIP  = 5'd7
	} opcode_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_MOD1,
		S_MOD2,
		S_READ,
		S_EXEC,
		S_DONE
	} state_t;

endpackage

[rtl/ams_ram.sv]
module ams_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/accumulator_machine_step_top.sv]
// After a request is accepted the states run: mode 3 straight to DONE; write MOD1, MOD2, DONE;
// read MOD1, MOD2, READ, DONE; execute FETCH, MOD1, MOD2, DONE, with EXEC before DONE for load,
// add and subtract, which read an operand. A new request is taken the cycle after done, so
// requests do not overlap; the single-port store (instruction read, operand read) and the address
// reduction in MOD1 and MOD2 set this sequence. After reset a clearing pass writes zero to every
// store word with busy high. Results are strobed for one cycle on done; the receiver cannot stall.
module accumulator_machine_step_top
	import ams_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            mode,
	input  logic [WAW-1:0]        word_address,
	input  logic [WW-1:0]         word_value,
	output logic                  done,
	output logic [PCW-1:0]        pc_now,
	output logic signed [WW-1:0]  acc_now,
	output logic [WW-1:0]         last_instruction,
	output logic [WW-1:0]         read_value
);

`include "accumulator_machine_step_top_macros.svh"

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [RW-1:0] RECIP = RW'((2**RSH + STORE_DEPTH - 1) / STORE_DEPTH);

	state_t state_q, state_d;

	logic [AW-1:0]  clr_q;
	logic [AW-1:0]  pc_q;
	logic [WW-1:0]  acc_q;
	logic [WW-1:0]  ir_q;
	logic [WW-1:0]  rd_q;
	mode_t          mode_q;
	logic [WW-1:0]  val_q;
	logic [OPW-1:0] op_q;
	logic [OPW-1:0] quo_q;

	logic           accept;
	logic           mem_we;
	logic [AW-1:0]  mem_addr;
	logic [WW-1:0]  mem_wdata;
	logic [WW-1:0]  mem_rdata;

	logic [OPW+RW-1:0] prod;
	logic [2*OPW:0]    qd_full;
	logic [AW-1:0]     red_addr;
	opcode_t           ir_op;
	logic [AW:0]       pc_sum;
	logic [AW-1:0]     pc_nx;

	assign accept = start && !busy;
	assign ir_op  = opcode_t'(ir_q[WW-1 -: OCW]);

	// modulo by the depth: reciprocal multiply, then subtract quotient times depth
	assign prod     = (OPW+RW)'(op_q) * (OPW+RW)'(RECIP);
	assign qd_full  = (2*OPW+1)'(quo_q) * (2*OPW+1)'(STORE_DEPTH);
	assign red_addr = AW'(op_q - OPW'(qd_full));

	always_comb begin
		pc_sum = {1'b0, pc_q} + (((mem_rdata[WW-1 -: OCW] == OP_SKIP) && !acc_q[WW-1])
			? (AW+1)'(2) : (AW+1)'(1));
		if (pc_sum >= (AW+1)'(STORE_DEPTH)) begin
			pc_nx = AW'(pc_sum - (AW+1)'(STORE_DEPTH));
		end else begin
			pc_nx = AW'(pc_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		done      = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = pc_q;
		mem_wdata = acc_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(STORE_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					case (mode_t'(mode))
						MODE_EXEC:  state_d = S_FETCH;
						MODE_WRITE: state_d = S_MOD1;
						MODE_READ:  state_d = S_MOD1;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_FETCH: state_d = S_MOD1;
			S_MOD1:  state_d = S_MOD2;
			S_MOD2: begin
				mem_addr = red_addr;
				case (mode_q)
					MODE_WRITE: begin
						mem_we    = 1'b1;
						mem_wdata = val_q;
						state_d   = S_DONE;
					end
					MODE_READ: state_d = S_READ;
					default: begin
						case (ir_op)
							OP_STORE: begin
								mem_we  = 1'b1;
								state_d = S_DONE;
							end
							OP_LOAD, OP_ADD, OP_SUB: state_d = S_EXEC;
							default: state_d = S_DONE;
						endcase
					end
				endcase
			end
			S_READ:  state_d = S_DONE;
			S_EXEC:  state_d = S_DONE;
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pc_q  <= '0;
			acc_q <= '0;
			ir_q  <= '0;
			rd_q  <= '0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				rd_q <= '0;
			end
			if (state_q == S_FETCH) begin
				ir_q <= mem_rdata;
				pc_q <= pc_nx;
			end
			if (state_q == S_READ) begin
				rd_q <= mem_rdata;
			end
			if (state_q == S_EXEC) begin
				case (ir_op)
					OP_LOAD: acc_q <= mem_rdata;
					OP_ADD:  acc_q <= acc_q + mem_rdata;
					OP_SUB:  acc_q <= acc_q - mem_rdata;
					default: acc_q <= acc_q;
				endcase
			end
		end
	end

	// request payload and modulo operands
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			val_q  <= word_value;
			op_q   <= OPW'(word_address);
		end
		if (state_q == S_FETCH) begin
			op_q <= mem_rdata[OPW-1:0];
		end
		if (state_q == S_MOD1) begin
			quo_q <= OPW'(prod >> RSH);
		end
	end

	ams_ram #(
		.WIDTH(WW),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign pc_now           = PCW'(pc_q);
	assign acc_now          = $signed(acc_q);
	assign last_instruction = ir_q;
	assign read_value       = rd_q;

	`AMS_ASSERT_IMP(a_pc_range, 1'b1, pc_q <= AW'(STORE_DEPTH - 1))
	`AMS_ASSERT_NXT(a_done_single, done, !done && !busy)
	`AMS_ASSERT_IMP(a_write_lands, $past(accept, 2) && ($past(mode, 2) == MODE_WRITE),
		mem_we && (mem_wdata == $past(word_value, 2)))
	`AMS_ASSERT_IMP(a_rd_zero, done && (mode_q != MODE_READ), read_value == '0)

endmodule
